[rtl/dhoat_pkg.sv]
// Shared codes and types for the double-hashed open-address table.
package dhoat_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam int HASH_W = 64;

    // slot count; the output fields are sized for it
    localparam int TABLE_SIZE = 4096;
    localparam int SLOT_W     = 12;

    typedef struct packed {
        logic clear_done;
        logic key_release;
    } dhoat_back_stat_t;

endpackage

[rtl/dhoat_if.sv]
// Input and output channel interfaces of the table.
interface dhoat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] record_handle;

    modport source (output valid, operation, key_byte, key_last, record_handle, input ready);
    modport sink   (input valid, operation, key_byte, key_last, record_handle, output ready);
endinterface

interface dhoat_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] found_handle;
    logic [11:0] slot_index;
    logic [12:0] entry_count;
    logic [31:0] collision_total;

    modport source (output valid, status, found_handle, slot_index, entry_count,
                    collision_total, input ready);
    modport sink   (input valid, status, found_handle, slot_index, entry_count,
                    collision_total, output ready);
endinterface

[rtl/double_hash_open_address_table.sv]
// Top level: string-keyed double-hashed open-address table.
//
// Input channel in_ch carries one key byte per transaction with operation
// (taken from the first byte), key_last and record_handle (taken from the
// last byte). Output channel out_ch returns one result per key.
// Key bytes are taken at one per cycle while in_ch.ready is high. After
// the last byte the front end reduces the two 64-bit hashes to start slot
// and step in its F_MOD state (a mask and a chunk fold), then hands a
// command to the back end through a two-entry queue.
// For each probed slot the back end reads the slot stores (B_PRD) and
// checks them (B_PEV); for each key byte it compares (B_CRD, B_CEV) or
// copies (B_WRD, B_WWR) a key, and B_OUT loads the result register. A
// full-table insert probes TABLE_SIZE slots. The first byte of a new key
// waits until the back end has loaded the result of the previous key; later
// bytes hash meanwhile. After reset a clearing pass zeroes the slot flags;
// in_ch.ready stays low during it. A stalled receiver holds the result
// register and the back end waits in place.
module double_hash_open_address_table
    import dhoat_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 39
) (
    input  logic        clk,
    input  logic        rst_n,
    dhoat_in_if.sink    in_ch,
    dhoat_out_if.source out_ch
);
    localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KI_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CMD_W  = 2 + LEN_W + 32 + 2 * SLOT_W;

    dhoat_back_stat_t  stat;
    logic              f_valid, f_ready, b_valid, b_ready;
    logic [CMD_W-1:0]  f_data, b_data;
    logic [KI_W-1:0]   qrd_addr;
    logic [7:0]        qrd_data;

    dhoat_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .LEN_W         (LEN_W),
        .KI_W          (KI_W),
        .CMD_W         (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .stat      (stat),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data),
        .qrd_addr  (qrd_addr),
        .qrd_data  (qrd_data)
    );

    dhoat_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    dhoat_back #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .LEN_W         (LEN_W),
        .KI_W          (KI_W),
        .CMD_W         (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_data  (b_data),
        .qrd_addr  (qrd_addr),
        .qrd_data  (qrd_data),
        .stat      (stat),
        .out_ch    (out_ch)
    );
endmodule

[rtl/dhoat_fifo.sv]
// Two-entry command queue between the front and back ends.
module dhoat_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end
endmodule

[rtl/dhoat_front.sv]
// Front end: key byte capture, hashing and start/step reduction.
module dhoat_front
    import dhoat_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 39,
    parameter int LEN_W         = $clog2(MAX_KEY_BYTES + 1),
    parameter int KI_W          = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
    parameter int CMD_W         = 2 + LEN_W + 32 + 2 * SLOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    dhoat_in_if.sink          in_ch,
    input  dhoat_back_stat_t  stat,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output logic [CMD_W-1:0]  cmd_data,
    input  logic [KI_W-1:0]   qrd_addr,
    output logic [7:0]        qrd_data
);
    localparam logic [1:0] F_HASH = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [SLOT_W:0] MOD_B = (SLOT_W + 1)'(TABLE_SIZE - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_KEY_BYTES);

    logic [7:0]        qbuf [MAX_KEY_BYTES];
    logic [1:0]        fst_reg, fst_next;
    logic [LEN_W-1:0]  qlen_reg, qlen_next;
    logic [HASH_W-1:0] ha_reg, ha_next, hb_reg, hb_next;
    logic [HASH_W-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [SLOT_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       hdl_reg, hdl_next;
    logic              busy_reg, busy_next;
    logic              accept, take;
    logic [HASH_W-1:0] ha_upd, hb_upd;
    logic [SLOT_W+2:0] fold_sum;
    logic [SLOT_W:0]   fold_two;
    logic [SLOT_W-1:0] fold_red;
    logic [SLOT_W-1:0] step;

    assign in_ch.ready = stat.clear_done && (fst_reg == F_HASH)
                         && !((qlen_reg == '0) && busy_reg);
    assign accept = in_ch.valid && in_ch.ready;
    assign take   = qlen_reg < LEN_MAX;

    assign ha_upd = take ? ((ha_reg << 5) - ha_reg + {56'd0, in_ch.key_byte}) : ha_reg;
    assign hb_upd = take ? ((hb_reg << 5) + hb_reg + {56'd0, in_ch.key_byte}) : hb_reg;

    // 2**SLOT_W is 1 modulo TABLE_SIZE-1, so summing the slot-wide chunks keeps the residue
    assign fold_sum = (SLOT_W + 3)'(sb_reg[SLOT_W-1:0])
                    + (SLOT_W + 3)'(sb_reg[2*SLOT_W-1:SLOT_W])
                    + (SLOT_W + 3)'(sb_reg[3*SLOT_W-1:2*SLOT_W])
                    + (SLOT_W + 3)'(sb_reg[4*SLOT_W-1:3*SLOT_W])
                    + (SLOT_W + 3)'(sb_reg[5*SLOT_W-1:4*SLOT_W])
                    + (SLOT_W + 3)'(sb_reg[HASH_W-1:5*SLOT_W]);
    assign fold_two = {1'b0, fold_sum[SLOT_W-1:0]} + (SLOT_W + 1)'(fold_sum[SLOT_W+2:SLOT_W]);
    assign fold_red = (fold_two >= MOD_B) ? SLOT_W'(fold_two - MOD_B) : SLOT_W'(fold_two);

    assign step  = rb_reg + SLOT_W'(1);

    assign cmd_valid = (fst_reg == F_PUSH);
    assign cmd_data  = {op_reg, qlen_reg, hdl_reg, ra_reg, step};

    always_comb
    begin
        fst_next  = fst_reg;
        qlen_next = qlen_reg;
        ha_next   = ha_reg;
        hb_next   = hb_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        op_next   = op_reg;
        hdl_next  = hdl_reg;
        busy_next = busy_reg && !stat.key_release;
        case (fst_reg)
            F_HASH:
            begin
                if (accept)
                begin
                    if (qlen_reg == '0)
                    begin
                        op_next = in_ch.operation;
                    end
                    if (take)
                    begin
                        qlen_next = qlen_reg + LEN_W'(1);
                    end
                    ha_next = ha_upd;
                    hb_next = hb_upd;
                    if (in_ch.key_last)
                    begin
                        hdl_next = in_ch.record_handle;
                        sa_next  = ha_upd;
                        sb_next  = hb_upd;
                        fst_next = F_MOD;
                    end
                end
            end
            F_MOD:
            begin
                ra_next  = sa_reg[SLOT_W-1:0];
                rb_next  = fold_red;
                fst_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    busy_next = 1'b1;
                    qlen_next = '0;
                    ha_next   = '0;
                    hb_next   = '0;
                    fst_next  = F_HASH;
                end
            end
            default:
            begin
                fst_next = F_HASH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg  <= F_HASH;
            qlen_reg <= '0;
            ha_reg   <= '0;
            hb_reg   <= '0;
            op_reg   <= OP_INSERT;
            busy_reg <= 1'b0;
        end
        else
        begin
            fst_reg  <= fst_next;
            qlen_reg <= qlen_next;
            ha_reg   <= ha_next;
            hb_reg   <= hb_next;
            op_reg   <= op_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        hdl_reg <= hdl_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && take)
        begin
            qbuf[qlen_reg[KI_W-1:0]] <= in_ch.key_byte;
        end
        qrd_data <= qbuf[qrd_addr];
    end
endmodule

[rtl/dhoat_back.sv]
// Back end: probe walk over the slot stores and result register.
module dhoat_back
    import dhoat_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 39,
    parameter int LEN_W         = $clog2(MAX_KEY_BYTES + 1),
    parameter int KI_W          = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
    parameter int CMD_W         = 2 + LEN_W + 32 + 2 * SLOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [CMD_W-1:0]  cmd_data,
    output logic [KI_W-1:0]   qrd_addr,
    input  logic [7:0]        qrd_data,
    output dhoat_back_stat_t  stat,
    dhoat_out_if.source       out_ch
);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_PRD   = 4'd2;
    localparam logic [3:0] B_PEV   = 4'd3;
    localparam logic [3:0] B_CRD   = 4'd4;
    localparam logic [3:0] B_CEV   = 4'd5;
    localparam logic [3:0] B_WRD   = 4'd6;
    localparam logic [3:0] B_WWR   = 4'd7;
    localparam logic [3:0] B_OUT   = 4'd8;
    localparam logic [SLOT_W:0]  SIZE_EXT  = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] LAST_TRY  = CNT_W'(TABLE_SIZE - 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SIZE - 1);

    // flag bit 0: occupied, bit 1: tombstone
    logic [1:0]       flag_mem [TABLE_SIZE];
    logic [LEN_W-1:0] len_mem  [TABLE_SIZE];
    logic [31:0]      hdl_mem  [TABLE_SIZE];
    logic [7:0]       key_mem  [TABLE_SIZE][MAX_KEY_BYTES];

    logic [1:0]        flag_q;
    logic [LEN_W-1:0]  len_q;
    logic [31:0]       hdl_q;
    logic [7:0]        kbyte_q;

    logic [3:0]        st_reg, st_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  tries_reg, tries_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [1:0]        op_reg, op_next;
    logic [LEN_W-1:0]  qlen_reg, qlen_next;
    logic [31:0]       chdl_reg, chdl_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       col_reg, col_next;
    logic [2:0]        rst_code_reg, rst_code_next;
    logic [31:0]       rhdl_reg, rhdl_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;

    logic              ov_reg, ov_next;
    logic [2:0]        ostat_reg;
    logic [31:0]       ohdl_reg, ocol_reg;
    logic [11:0]       oslot_reg;
    logic [12:0]       ocnt_reg;

    logic              flag_we, key_we, ent_we;
    logic [1:0]        flag_wd;
    logic [SLOT_W:0]   adv_sum;
    logic [SLOT_W-1:0] adv_idx;
    logic              last_byte, out_load, pop;
    logic [1:0]        c_op;
    logic [LEN_W-1:0]  c_len;
    logic [31:0]       c_hdl;
    logic [SLOT_W-1:0] c_start, c_step;

    assign {c_op, c_len, c_hdl, c_start, c_step} = cmd_data;
    assign cmd_ready = (st_reg == B_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign qrd_addr  = j_reg[KI_W-1:0];
    assign adv_sum   = {1'b0, idx_reg} + {1'b0, step_reg};
    assign adv_idx   = (adv_sum >= SIZE_EXT) ? SLOT_W'(adv_sum - SIZE_EXT) : SLOT_W'(adv_sum);
    assign last_byte = (LEN_W'(j_reg + LEN_W'(1)) == qlen_reg);
    assign out_load  = (st_reg == B_OUT) && (!ov_reg || out_ch.ready);

    assign stat.clear_done  = (st_reg != B_CLEAR);
    assign stat.key_release = out_load;

    assign out_ch.valid           = ov_reg;
    assign out_ch.status          = ostat_reg;
    assign out_ch.found_handle    = ohdl_reg;
    assign out_ch.slot_index      = oslot_reg;
    assign out_ch.entry_count     = ocnt_reg;
    assign out_ch.collision_total = ocol_reg;

    always_comb
    begin
        st_next       = st_reg;
        idx_next      = idx_reg;
        tries_next    = tries_reg;
        j_next        = j_reg;
        op_next       = op_reg;
        qlen_next     = qlen_reg;
        chdl_next     = chdl_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        col_next      = col_reg;
        rst_code_next = rst_code_reg;
        rhdl_next     = rhdl_reg;
        rslot_next    = rslot_reg;
        flag_we       = 1'b0;
        flag_wd       = 2'b00;
        key_we        = 1'b0;
        ent_we        = 1'b0;
        case (st_reg)
            B_CLEAR:
            begin
                flag_we  = 1'b1;
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    st_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    op_next       = c_op;
                    qlen_next     = c_len;
                    chdl_next     = c_hdl;
                    step_next     = c_step;
                    idx_next      = c_start;
                    tries_next    = '0;
                    rst_code_next = ST_NOT_FOUND;
                    rhdl_next     = '0;
                    rslot_next    = '0;
                    if (c_op == OP_INSERT || c_op == OP_LOOKUP || c_op == OP_DELETE)
                    begin
                        st_next = B_PRD;
                    end
                    else
                    begin
                        st_next = B_OUT;
                    end
                end
            end
            B_PRD:
            begin
                st_next = B_PEV;
            end
            B_PEV:
            begin
                j_next = '0;
                if (op_reg == OP_INSERT)
                begin
                    if (!flag_q[0])
                    begin
                        st_next = B_WRD;
                    end
                    else
                    begin
                        if (col_reg != '1)
                        begin
                            col_next = col_reg + 32'd1;
                        end
                        if (tries_reg == LAST_TRY)
                        begin
                            rst_code_next = ST_FULL;
                            st_next       = B_OUT;
                        end
                        else
                        begin
                            tries_next = tries_reg + CNT_W'(1);
                            idx_next   = adv_idx;
                            st_next    = B_PRD;
                        end
                    end
                end
                else if (!flag_q[0] && !flag_q[1])
                begin
                    st_next = B_OUT;
                end
                else if (flag_q[0] && (len_q == qlen_reg))
                begin
                    st_next = B_CRD;
                end
                else if (tries_reg == LAST_TRY)
                begin
                    st_next = B_OUT;
                end
                else
                begin
                    tries_next = tries_reg + CNT_W'(1);
                    idx_next   = adv_idx;
                    st_next    = B_PRD;
                end
            end
            B_CRD:
            begin
                st_next = B_CEV;
            end
            B_CEV:
            begin
                if (qrd_data != kbyte_q)
                begin
                    // mismatch: move on to the next probe
                    if (tries_reg == LAST_TRY)
                    begin
                        st_next = B_OUT;
                    end
                    else
                    begin
                        tries_next = tries_reg + CNT_W'(1);
                        idx_next   = adv_idx;
                        st_next    = B_PRD;
                    end
                end
                else if (last_byte)
                begin
                    rslot_next = idx_reg;
                    st_next    = B_OUT;
                    if (op_reg == OP_LOOKUP)
                    begin
                        rst_code_next = ST_FOUND;
                        rhdl_next     = hdl_q;
                    end
                    else
                    begin
                        rst_code_next = ST_DELETED;
                        flag_we       = 1'b1;
                        flag_wd       = 2'b10;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    j_next  = j_reg + LEN_W'(1);
                    st_next = B_CRD;
                end
            end
            B_WRD:
            begin
                st_next = B_WWR;
            end
            B_WWR:
            begin
                key_we = 1'b1;
                if (last_byte)
                begin
                    ent_we        = 1'b1;
                    flag_we       = 1'b1;
                    flag_wd       = 2'b01;
                    count_next    = count_reg + CNT_W'(1);
                    rst_code_next = ST_INSERTED;
                    rslot_next    = idx_reg;
                    st_next       = B_OUT;
                end
                else
                begin
                    j_next  = j_reg + LEN_W'(1);
                    st_next = B_WRD;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= B_CLEAR;
            idx_reg   <= '0;
            tries_reg <= '0;
            j_reg     <= '0;
            op_reg    <= OP_INSERT;
            count_reg <= '0;
            col_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            idx_reg   <= idx_next;
            tries_reg <= tries_next;
            j_reg     <= j_next;
            op_reg    <= op_next;
            count_reg <= count_next;
            col_reg   <= col_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qlen_reg     <= qlen_next;
        chdl_reg     <= chdl_next;
        step_reg     <= step_next;
        rst_code_reg <= rst_code_next;
        rhdl_reg     <= rhdl_next;
        rslot_reg    <= rslot_next;
        if (out_load)
        begin
            ostat_reg <= rst_code_reg;
            ohdl_reg  <= rhdl_reg;
            oslot_reg <= 12'(rslot_reg);
            ocnt_reg  <= 13'(count_reg);
            ocol_reg  <= col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[idx_reg] <= flag_wd;
        end
        flag_q <= flag_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            len_mem[idx_reg] <= qlen_reg;
            hdl_mem[idx_reg] <= chdl_reg;
        end
        len_q <= len_mem[idx_reg];
        hdl_q <= hdl_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[idx_reg][j_reg[KI_W-1:0]] <= qrd_data;
        end
        kbyte_q <= key_mem[idx_reg][j_reg[KI_W-1:0]];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SIZE))
        else $error("entry count above table size");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");

    a_col_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != B_CLEAR) |=> (col_reg >= $past(col_reg)))
        else $error("collision total went down");

    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (st_reg == B_IDLE))
        else $error("back end did not return to idle after result");

    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        stat.key_release |=> !stat.key_release)
        else $error("key buffer released twice");
endmodule
